### src/oli_pkg.sv
package oli_pkg;

  // Fixed field widths of the item and result transactions
  localparam int ACTION_W = 3;
  localparam int TOKEN_W  = 16;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  // Defaults for the top-level parameters
  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_TOKEN_BITS = 16;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_END   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INS_POS   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DELETE    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ      = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture an accepted item and decode it
    logic step;    // advance the scan/shift engine one entry
    logic finish;  // commit the count and the final write
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;  // no read left to issue and none in flight
  } stat_t;

endpackage

### src/oli_item_if.sv
interface oli_item_if import oli_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [TOKEN_W-1:0]  token_value;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, output action, output token_value, output slot, input ready);
  modport sink   (input valid, input action, input token_value, input slot, output ready);
endinterface

### src/oli_result_if.sv
interface oli_result_if import oli_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  logic [TOKEN_W-1:0]  read_token;

  modport source (output valid, output status, output entry_count, output read_token,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input read_token,
                  output ready);
endinterface

### src/ordered_list_insert_delete.sv
// Flow: the block accepts an item only when idle and takes no new item until the result
//   of the last one is taken. Insert moves count-pos entries, delete scans all count
//   entries, read fetches one; the single read port of the token store limits the scan
//   to one entry a cycle.
// Reset: synchronous; clears the count and control state, the store is not cleared.
module ordered_list_insert_delete import oli_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int TOKEN_BITS = DEF_TOKEN_BITS
) (
  input logic          clk,
  input logic          rst,
  oli_item_if.sink     item,
  oli_result_if.source result
);

  // Command and status between the sequencer and the list datapath
  cmd_t  cmd;
  stat_t stat;

  // Sequencer: accept one transaction, run the scan, commit, hold the result
  oli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: token store, count, shift/search engine and result registers.
  // The result fields come straight from registers that hold while the
  // sequencer waits for the result to be taken.
  oli_dp #(
    .CAPACITY   (CAPACITY),
    .TOKEN_BITS (TOKEN_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (item.action),
    .token_value (item.token_value),
    .slot        (item.slot),
    .status      (result.status),
    .entry_count (result.entry_count),
    .read_token  (result.read_token)
  );

endmodule

### src/oli_ctrl.sv
module oli_ctrl import oli_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_RESULT);
  assign cmd.load   = in_valid && (state == S_IDLE);
  assign cmd.step   = (state == S_SCAN);
  assign cmd.finish = (state == S_FINISH);

endmodule

### src/oli_dp.sv
module oli_dp import oli_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int TOKEN_BITS = DEF_TOKEN_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [ACTION_W-1:0] action,
  input  logic [TOKEN_W-1:0]  token_value,
  input  logic [SLOT_W-1:0]   slot,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  entry_count,
  output logic [TOKEN_W-1:0]  read_token
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > SLOT_W) ? CW : SLOT_W) + 1;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_INS  = 2'd1,
    K_DEL  = 2'd2,
    K_RD   = 2'd3
  } kind_t;

  // Token store
  logic [TOKEN_BITS-1:0] mem [CAPACITY];
  logic [TOKEN_BITS-1:0] rdata;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [TOKEN_BITS-1:0] wd;

  // Control state
  logic [CW-1:0] count;
  kind_t         kind;
  logic [CW-1:0] rem;
  logic          pend;
  logic          found;

  // Item payload and scan addresses
  logic [TOKEN_BITS-1:0] tok;
  logic [AW-1:0]         pos;
  logic [AW-1:0]         rd_idx;
  logic [AW-1:0]         pend_addr;
  logic [TOKEN_BITS-1:0] rd_token;

  // Decode of the incoming item
  kind_t               ld_kind;
  logic [STATUS_W-1:0] ld_status;
  logic [AW-1:0]       ld_pos;
  logic [CW-1:0]       ld_rem;
  logic [AW-1:0]       ld_idx;
  logic [XW-1:0]       slot_x;
  logic [XW-1:0]       cnt_x;
  logic                is_full;

  assign slot_x  = XW'(slot);
  assign cnt_x   = XW'(count);
  assign is_full = (count == CW'(CAPACITY));

  always_comb begin
    ld_kind   = K_NONE;
    ld_status = ST_OK;
    ld_pos    = '0;
    ld_rem    = '0;
    ld_idx    = '0;
    unique case (action)
      ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
        if (is_full) begin
          ld_status = ST_FULL;
        end else if (action == ACT_INS_FRONT) begin
          ld_kind = K_INS;
          ld_pos  = '0;
        end else if (action == ACT_INS_END) begin
          ld_kind = K_INS;
          ld_pos  = AW'(count);
        end else if (slot_x <= XW'(1)) begin
          ld_kind = K_INS;
          ld_pos  = '0;
        end else if (slot_x - XW'(1) > cnt_x) begin
          ld_status = ST_BADPOS;
        end else begin
          ld_kind = K_INS;
          ld_pos  = AW'(slot_x - XW'(1));
        end
        // Move entries pos..count-1 up by one, last one first
        ld_rem = count - CW'(ld_pos);
        ld_idx = AW'(count - CW'(1));
      end
      ACT_DELETE: begin
        if (count == '0) begin
          ld_status = ST_EMPTY;
        end else begin
          ld_kind = K_DEL;
          ld_rem  = count;
          ld_idx  = '0;
        end
      end
      ACT_READ: begin
        if (slot_x >= cnt_x) begin
          ld_status = ST_RANGE;
        end else begin
          ld_kind = K_RD;
          ld_rem  = CW'(1);
          ld_idx  = AW'(slot);
        end
      end
      default: begin
        ld_kind   = K_NONE;
        ld_status = ST_OK;
      end
    endcase
    if (ld_kind != K_INS && ld_kind != K_DEL && ld_kind != K_RD) begin
      ld_rem = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      kind  <= K_NONE;
      rem   <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.load) begin
      kind  <= ld_kind;
      rem   <= ld_rem;
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.step) begin
      if (rem != '0) begin
        rem  <= rem - CW'(1);
        pend <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
      if (pend && kind == K_DEL && !found && rdata == tok) begin
        found <= 1'b1;
      end
    end else if (cmd.finish) begin
      if (kind == K_INS) begin
        count <= count + CW'(1);
      end else if (kind == K_DEL && found) begin
        count <= count - CW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tok      <= TOKEN_BITS'(token_value);
      pos      <= ld_pos;
      rd_idx   <= ld_idx;
      status   <= ld_status;
      rd_token <= '0;
    end else if (cmd.step) begin
      if (rem != '0) begin
        pend_addr <= rd_idx;
        rd_idx    <= (kind == K_DEL) ? rd_idx + AW'(1) : rd_idx - AW'(1);
      end
      if (pend && kind == K_RD) begin
        rd_token <= rdata;
      end
    end else if (cmd.finish) begin
      if (kind == K_DEL && !found) begin
        status <= ST_NOTFOUND;
      end
    end
  end

  // Write port: shift traffic during the scan, the new token at finish
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rdata;
    if (cmd.finish && kind == K_INS) begin
      we = 1'b1;
      wa = pos;
      wd = tok;
    end else if (cmd.step && pend && kind == K_INS) begin
      we = 1'b1;
      wa = pend_addr + AW'(1);
    end else if (cmd.step && pend && kind == K_DEL && found) begin
      we = 1'b1;
      wa = pend_addr - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[rd_idx];
  end

  assign stat.scan_done = (rem == '0) && !pend;
  assign entry_count    = COUNT_W'(count);
  assign read_token     = TOKEN_W'(rd_token);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && kind == K_INS) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the list by one");

  a_found_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && kind == K_DEL && found) |=> found)
    else $error("match flag dropped during delete shift");

  a_pend_follows_read: assert property (@(posedge clk) disable iff (rst)
    (pend && !$past(rst)) |-> $past(cmd.step && rem != '0))
    else $error("read data flagged without a read issued");

endmodule

### dv/oli_list_checker.sv
`timescale 1ns / 100ps

module oli_list_checker import oli_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int TOKEN_BITS = DEF_TOKEN_BITS
) (
  input  logic  clk,
  input  logic  rst,
  oli_item_if   item,
  oli_result_if result,
  output int    fail_count,
  output int    outstanding
);

  localparam int KEEP_BITS = (TOKEN_BITS < TOKEN_W) ? TOKEN_BITS : TOKEN_W;
  localparam logic [TOKEN_W-1:0] TOKEN_MASK = TOKEN_W'((64'd1 << KEEP_BITS) - 64'd1);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
    logic [TOKEN_W-1:0]  read_token;
  } list_result_t;

  logic [TOKEN_W-1:0] held_tokens[$];
  list_result_t       expected_results[$];
  int                 mismatch_total = 0;

  assign fail_count  = mismatch_total;
  assign outstanding = expected_results.size();

  // Apply one list operation to the shadow list and return its result.
  function automatic list_result_t apply_list_op(input logic [ACTION_W-1:0] act,
                                                 input logic [TOKEN_W-1:0]  tok_in,
                                                 input logic [SLOT_W-1:0]   slot);
    list_result_t       res;
    logic [TOKEN_W-1:0] tok;
    int                 pos;
    int                 hit;
    tok            = tok_in & TOKEN_MASK;
    pos            = int'(slot) - 1;
    hit            = -1;
    res.status     = ST_OK;
    res.read_token = '0;
    case (act)
      ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
        if (held_tokens.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (act == ACT_INS_FRONT || (act == ACT_INS_POS && slot <= 1)) begin
          held_tokens.push_front(tok);
        end else if (act == ACT_INS_END || pos == held_tokens.size()) begin
          held_tokens.push_back(tok);
        end else if (pos > held_tokens.size()) begin
          res.status = ST_BADPOS;
        end else begin
          held_tokens.insert(pos, tok);
        end
      end
      ACT_DELETE: begin
        if (held_tokens.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < held_tokens.size() && hit < 0; i++)
            if (held_tokens[i] == tok) hit = i;
          if (hit < 0) res.status = ST_NOTFOUND;
          else held_tokens.delete(hit);
        end
      end
      ACT_READ: begin
        if (int'(slot) >= held_tokens.size()) res.status = ST_RANGE;
        else res.read_token = held_tokens[slot];
      end
      default: ;
    endcase
    res.entry_count = COUNT_W'(held_tokens.size());
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_total++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // Retire the result before taking the new item, so a result cannot match
  // an expectation pushed at the same edge.
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      held_tokens.delete();
      expected_results.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_total++;
          $display("%0t: unexpected result, expected none actual status %0d count %0d token %0h",
                   $time, result.status, result.entry_count, result.read_token);
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, result.status);
          check_field("entry_count", want.entry_count, result.entry_count);
          check_field("read_token", want.read_token, result.read_token);
        end
      end
      if (item.valid && item.ready)
        expected_results.push_back(apply_list_op(item.action, item.token_value, item.slot));
    end
  end

endmodule

### dv/ordered_list_insert_delete_tb.sv
`timescale 1ns / 100ps

module ordered_list_insert_delete_tb import oli_pkg::*;;

  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int TOKEN_BITS   = DEF_TOKEN_BITS;
  localparam int RANDOM_ITEMS = 1800;
  // Generous limit for the whole run, several times the worst case per item.
  localparam int CYCLE_LIMIT  = 600000;

  // Actions the block decodes as no-ops
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_t;

  logic clk;
  logic rst;
  logic no_idle;
  int   cycle_count = 0;
  int   fail_count;
  int   outstanding;

  // Tokens recently offered for insertion; deletes draw from here so most hit.
  logic [TOKEN_W-1:0] token_history[$];
  logic [TOKEN_W-1:0] token_pool[8] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                                        16'h5555, 16'hAAAA, 16'h1234, 16'h7FFF};

  oli_item_if   item_ch();
  oli_result_if result_ch();

  ordered_list_insert_delete #(
    .CAPACITY  (CAPACITY),
    .TOKEN_BITS(TOKEN_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  oli_list_checker #(
    .CAPACITY  (CAPACITY),
    .TOKEN_BITS(TOKEN_BITS)
  ) list_check (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result side about 6 percent of the time, except in the calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= no_idle || ($urandom_range(99) >= 6);
    end
  end

  // Watchdog: abort the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ordered_list_insert_delete regression: fail");
      $finish;
    end
  end

  // Present one transaction and hold it until the block takes it. Valid stays high
  // between back-to-back transactions; drop it only for an idle gap.
  task automatic send_op(input logic [ACTION_W-1:0] act, input logic [TOKEN_W-1:0] tok,
                         input logic [SLOT_W-1:0] pos);
    if (!no_idle && $urandom_range(99) < 6) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.action      <= act;
    item_ch.token_value <= tok;
    item_ch.slot        <= pos;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (act == ACT_INS_FRONT || act == ACT_INS_END || act == ACT_INS_POS) begin
      token_history.push_back(tok);
      if (token_history.size() > CAPACITY) void'(token_history.pop_front());
    end
  endtask

  function automatic logic [TOKEN_W-1:0] pick_token();
    if ($urandom_range(99) < 70) return token_pool[$urandom_range(7)];
    return TOKEN_W'($urandom_range(16'hFFFF));
  endfunction

  // Deletes mostly target something inserted earlier, otherwise any token.
  function automatic logic [TOKEN_W-1:0] pick_victim();
    if (token_history.size() > 0 && $urandom_range(99) < 75)
      return token_history[$urandom_range(token_history.size() - 1)];
    return pick_token();
  endfunction

  // Positions mostly near the live range of the list, sometimes anywhere.
  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(99) < 75) return SLOT_W'($urandom_range(CAPACITY + 2));
    return SLOT_W'($urandom_range(255));
  endfunction

  task automatic issue_random_op(input op_mix_t mix);
    int roll;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        // Slots stay tiny so most inserts land and the list reaches full.
        if (roll < 40) send_op(ACT_INS_FRONT, pick_token(), pick_slot());
        else if (roll < 75) send_op(ACT_INS_END, pick_token(), pick_slot());
        else send_op(ACT_INS_POS, pick_token(), SLOT_W'($urandom_range(3)));
      end
      MIX_DRAIN: begin
        if (roll < 75) send_op(ACT_DELETE, pick_victim(), pick_slot());
        else if (roll < 92) send_op(ACT_READ, pick_token(), pick_slot());
        else send_op(ACT_INS_END, pick_token(), pick_slot());
      end
      default: begin
        if (roll < 15) send_op(ACT_INS_FRONT, pick_token(), pick_slot());
        else if (roll < 30) send_op(ACT_INS_END, pick_token(), pick_slot());
        else if (roll < 45) send_op(ACT_INS_POS, pick_token(), pick_slot());
        else if (roll < 72) send_op(ACT_DELETE, pick_victim(), pick_slot());
        else if (roll < 95) send_op(ACT_READ, pick_token(), pick_slot());
        else send_op(ACT_SPARE_FIRST + ACTION_W'($urandom_range(2)), pick_token(),
                     pick_slot());
      end
    endcase
  endtask

  initial begin
    op_mix_t mix;
    int      issued;
    int      phase;
    int      phase_len;
    issued              = 0;
    phase               = 0;
    no_idle             = 1'b0;
    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.action      = ACT_INS_FRONT;
    item_ch.token_value = '0;
    item_ch.slot        = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list errors, no-op actions, front and past-end positions,
    // every insert flavor, reads across and beyond the list, delete hit and miss.
    send_op(ACT_READ, 16'h0000, 8'd0);
    send_op(ACT_DELETE, 16'h1234, 8'd0);
    send_op(ACT_SPARE_FIRST, 16'hFFFF, 8'd255);
    send_op(ACT_SPARE_LAST, 16'h0000, 8'd0);
    send_op(ACT_INS_POS, 16'hFFFF, 8'd0);
    send_op(ACT_INS_POS, 16'h0000, 8'd1);
    send_op(ACT_INS_POS, 16'h1234, 8'd3);
    send_op(ACT_INS_POS, 16'h4321, 8'd5);
    send_op(ACT_INS_POS, 16'h4321, 8'd255);
    send_op(ACT_INS_FRONT, 16'h5555, 8'd0);
    send_op(ACT_INS_END, 16'hAAAA, 8'd0);
    send_op(ACT_INS_POS, 16'h8000, 8'd3);
    for (int i = 0; i < 6; i++) send_op(ACT_READ, 16'h0000, SLOT_W'(i));
    send_op(ACT_READ, 16'h0000, 8'd6);
    send_op(ACT_READ, 16'hFFFF, 8'd255);
    send_op(ACT_DELETE, 16'h8000, 8'd0);
    send_op(ACT_DELETE, 16'hFFFF, 8'd0);
    send_op(ACT_DELETE, 16'h7777, 8'd0);
    send_op(ACT_DELETE, 16'hAAAA, 8'd0);

    // Random: rotate fill, balanced and drain phases so the list swings between
    // full and nearly empty; the fourth phase runs with no idling on either side.
    while (issued < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin
          mix       = MIX_FILL;
          phase_len = 80;
        end
        2: begin
          mix       = MIX_DRAIN;
          phase_len = $urandom_range(200, 100);
        end
        default: begin
          mix       = MIX_BALANCED;
          phase_len = (phase == 3) ? 200 : $urandom_range(200, 100);
        end
      endcase
      no_idle <= (phase == 3);
      repeat (phase_len) issue_random_op(mix);
      issued += phase_len;
      phase++;
    end
    item_ch.valid <= 1'b0;
    no_idle       <= 1'b0;

    // Drain every expected result, then give the block time for a stray one.
    while (outstanding != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("ordered_list_insert_delete regression: pass");
    end else begin
      $display("ordered_list_insert_delete regression: fail");
    end
    $finish;
  end

endmodule
